FILE: rtl/halving_waypoint_planner_macros.svh
// Assertion macros shared by the halving waypoint planner RTL.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef HALVING_WAYPOINT_PLANNER_MACROS_SVH
`define HALVING_WAYPOINT_PLANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HWP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HWP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hwp_pkg.sv
// Shared types and constants for the halving waypoint planner.
// No dependencies; imported by the controller, the datapath and the top level.
package hwp_pkg;

  localparam int unsigned NUM_SEGMENTS_DEF = 16;
  localparam int unsigned NUM_AXES         = 3;
  localparam int unsigned COORD_W          = 32;
  localparam int unsigned THR_W            = 31;
  localparam int unsigned IDX_W            = 5;
  localparam logic [THR_W-1:0] THR_RESET   = 31'd32768;

  typedef enum logic [1:0] {
    KIND_PLAN    = 2'd0,
    KIND_CHECK   = 2'd1,
    KIND_ADVANCE = 2'd2,
    KIND_UNUSED  = 2'd3
  } hwp_kind_e;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_LOW,
    OP_HIGH,
    OP_GOAL,
    OP_DIFF,
    OP_RESP
  } hwp_op_e;

  typedef struct packed {
    hwp_op_e op;
  } hwp_cmd_t;

  typedef struct packed {
    logic last_iter;
  } hwp_sts_t;

endpackage

FILE: rtl/hwp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hwp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/hwp_ctrl.sv
// Controller state machine of the halving waypoint planner.
// Depends on hwp_pkg and halving_waypoint_planner_macros.svh.
`include "halving_waypoint_planner_macros.svh"

module hwp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        kind_i,
  input  hwp_pkg::hwp_sts_t sts_i,
  output hwp_pkg::hwp_cmd_t cmd_o,
  output logic              busy
);
  import hwp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN_START,
    ST_PLAN_LOW,
    ST_PLAN_HIGH,
    ST_PLAN_GOAL,
    ST_READ,
    ST_DIFF,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_LOAD;
          state_d  = (hwp_kind_e'(kind_i) == KIND_PLAN) ? ST_PLAN_START : ST_READ;
        end
      end
      ST_PLAN_START: begin
        cmd_o.op = OP_START;
        state_d  = ST_PLAN_LOW;
      end
      ST_PLAN_LOW: begin
        cmd_o.op = OP_LOW;
        state_d  = ST_PLAN_HIGH;
      end
      ST_PLAN_HIGH: begin
        cmd_o.op = OP_HIGH;
        state_d  = sts_i.last_iter ? ST_PLAN_GOAL : ST_PLAN_LOW;
      end
      ST_PLAN_GOAL: begin
        cmd_o.op = OP_GOAL;
        state_d  = ST_READ;
      end
      ST_READ: begin
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        cmd_o.op = OP_RESP;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `HWP_ASSERT_NXT(a_accept_goes_busy, accept, busy, "accepted word did not start work")
  `HWP_ASSERT_NXT(a_resp_ends_item, state_q == ST_RESP, state_q == ST_IDLE,
                  "response state not followed by idle")
  `HWP_ASSERT_NXT(a_goal_then_read, state_q == ST_PLAN_GOAL, state_q == ST_READ,
                  "plan did not end with a table read")

endmodule

FILE: rtl/hwp_dpath.sv
// Datapath of the halving waypoint planner: waypoint table, pointer, checks.
// Depends on hwp_pkg, hwp_ram and halving_waypoint_planner_macros.svh.
`include "halving_waypoint_planner_macros.svh"

module hwp_dpath #(
  parameter int unsigned NUM_SEGMENTS = hwp_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  hwp_pkg::hwp_cmd_t                             cmd_i,
  output hwp_pkg::hwp_sts_t                             sts_o,
  input  logic [1:0]                                    kind_i,
  input  logic [hwp_pkg::NUM_AXES-1:0][hwp_pkg::COORD_W-1:0] pos_i,
  input  logic [hwp_pkg::NUM_AXES-1:0][hwp_pkg::COORD_W-1:0] goal_i,
  input  logic                                          cfg_we_i,
  input  logic [hwp_pkg::THR_W-1:0]                     cfg_wdata_i,
  output logic [hwp_pkg::NUM_AXES-1:0][hwp_pkg::COORD_W-1:0] wp_o,
  output logic                                          reached_o,
  output logic [hwp_pkg::IDX_W-1:0]                     index_o,
  output logic                                          done_o
);
  import hwp_pkg::*;

  localparam int unsigned DEPTH  = NUM_SEGMENTS + 1;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned HALF   = NUM_SEGMENTS / 2;
  localparam int unsigned WORD_W = NUM_AXES * COORD_W;
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(NUM_SEGMENTS);
  localparam logic [PTR_W-1:0] PTR_HALF  = PTR_W'(HALF);
  localparam logic [PTR_W-1:0] ITER_LAST = PTR_W'(HALF - 1);

  logic [NUM_AXES-1:0][COORD_W-1:0] start_q, goal_q, pos_q;
  logic [NUM_AXES-1:0][COORD_W:0]   part_q, diff_q;
  logic [NUM_AXES-1:0][COORD_W-1:0] wp_q;
  logic [1:0]                       kind_q;
  logic [THR_W-1:0]                 thr_q;
  logic [PTR_W-1:0]                 ptr_q, iter_q;
  logic                             reached_q, done_q;
  logic [IDX_W-1:0]                 index_q;

  logic                             we;
  logic [PTR_W-1:0]                 waddr;
  logic [NUM_AXES-1:0][COORD_W-1:0] wdata, rdata;
  logic [NUM_AXES-1:0][COORD_W:0]   low_sum, high_sum, span;
  logic [NUM_AXES-1:0]              axis_hit;
  logic signed [COORD_W:0]          thr_pos, thr_neg;
  logic [PTR_W+IDX_W-1:0]           ptr_ext;

  assign sts_o.last_iter = (iter_q == ITER_LAST);

  assign thr_pos = $signed({2'b00, thr_q});
  assign thr_neg = -thr_pos;
  assign ptr_ext = {{IDX_W{1'b0}}, ptr_q};

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      span[a]     = {goal_q[a][COORD_W-1], goal_q[a]} - {start_q[a][COORD_W-1], start_q[a]};
      low_sum[a]  = {start_q[a][COORD_W-1], start_q[a]} + part_q[a];
      high_sum[a] = {goal_q[a][COORD_W-1], goal_q[a]} - part_q[a];
      axis_hit[a] = ($signed(diff_q[a]) < thr_pos) && ($signed(diff_q[a]) > thr_neg);
    end
  end

  // Table write port: one entry per plan step.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = start_q;
    case (cmd_i.op)
      OP_START: begin
        we = 1'b1;
      end
      OP_LOW: begin
        we    = 1'b1;
        waddr = PTR_HALF - iter_q;
        for (int a = 0; a < NUM_AXES; a++) wdata[a] = low_sum[a][COORD_W-1:0];
      end
      OP_HIGH: begin
        we    = 1'b1;
        waddr = PTR_HALF + iter_q;
        for (int a = 0; a < NUM_AXES; a++) wdata[a] = high_sum[a][COORD_W-1:0];
      end
      OP_GOAL: begin
        we    = 1'b1;
        waddr = PTR_LAST;
        wdata = goal_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  hwp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  // Control registers: pointer, loop count, threshold, result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      iter_q <= '0;
      thr_q  <= THR_RESET;
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == OP_RESP);
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_LOAD) begin
        if (hwp_kind_e'(kind_i) == KIND_PLAN) begin
          ptr_q <= '0;
        end else if (hwp_kind_e'(kind_i) == KIND_ADVANCE && ptr_q != PTR_LAST) begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
      if (cmd_i.op == OP_START) begin
        iter_q <= '0;
      end else if (cmd_i.op == OP_HIGH) begin
        iter_q <= iter_q + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        kind_q  <= kind_i;
        start_q <= pos_i;
        pos_q   <= pos_i;
        goal_q  <= goal_i;
      end
      OP_START: begin
        for (int a = 0; a < NUM_AXES; a++) part_q[a] <= $signed(span[a]) >>> 1;
      end
      OP_HIGH: begin
        for (int a = 0; a < NUM_AXES; a++) part_q[a] <= $signed(part_q[a]) >>> 1;
      end
      OP_DIFF: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          diff_q[a] <= {rdata[a][COORD_W-1], rdata[a]} - {pos_q[a][COORD_W-1], pos_q[a]};
        end
      end
      OP_RESP: begin
        wp_q      <= rdata;
        reached_q <= (hwp_kind_e'(kind_q) == KIND_CHECK) && (&axis_hit);
        index_q   <= ptr_ext[IDX_W-1:0];
      end
      default: begin
        kind_q <= kind_q;
      end
    endcase
  end

  assign wp_o      = wp_q;
  assign reached_o = reached_q;
  assign index_o   = index_q;
  assign done_o    = done_q;

  `HWP_ASSERT_IMP(a_ptr_in_range, 1'b1, ptr_q <= PTR_LAST, "waypoint pointer past last entry")
  `HWP_ASSERT_NXT(a_single_strobe, done_q, !done_q, "result strobe held for two cycles")
  `HWP_ASSERT_IMP(a_plan_addr_ok, we, waddr <= PTR_LAST, "table write beyond last entry")

endmodule

FILE: rtl/halving_waypoint_planner.sv
// Top level of the halving waypoint planner: controller plus datapath.
// Depends on hwp_pkg, hwp_ctrl and hwp_dpath.

// The block keeps a table of NUM_SEGMENTS+1 waypoints per axis (signed Q16.16)
// and a pointer into it. Raise start with a word on kind_i and the coordinate
// ports; the word is taken at a rising edge where start is high and busy is
// low. kind 0 plans a new path from pos to goal and clears the pointer, kind 1
// checks whether every axis of pos lies strictly within reach_threshold of the
// current waypoint, kind 2 advances the pointer (it stops at NUM_SEGMENTS),
// kind 3 only reports. Every word yields exactly one result: done_o is high
// for one cycle with the waypoint at the pointer, the pointer and reached
// (0 except for a check). The receiver cannot stall; capture the result in
// the cycle done_o is high. A plan writes the start, then a low and a high
// entry per halving step, then the goal, through the single write port of
// the waypoint table, which takes one entry a cycle. busy drops in the
// done_o cycle, so the next word can be taken then. Write reach_threshold
// through cfg_we_i/cfg_wdata_i only while the block is idle; it resets to
// 0.5 (32768). Table entries that no plan has written read as garbage.
module halving_waypoint_planner #(
  parameter int unsigned NUM_SEGMENTS = hwp_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind_i,
  input  logic signed [hwp_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [hwp_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [hwp_pkg::COORD_W-1:0] pos_z_i,
  input  logic signed [hwp_pkg::COORD_W-1:0] goal_x_i,
  input  logic signed [hwp_pkg::COORD_W-1:0] goal_y_i,
  input  logic signed [hwp_pkg::COORD_W-1:0] goal_z_i,
  input  logic                         cfg_we_i,
  input  logic [hwp_pkg::THR_W-1:0]    cfg_wdata_i,
  output logic                         done_o,
  output logic signed [hwp_pkg::COORD_W-1:0] waypoint_x_o,
  output logic signed [hwp_pkg::COORD_W-1:0] waypoint_y_o,
  output logic signed [hwp_pkg::COORD_W-1:0] waypoint_z_o,
  output logic                         reached_o,
  output logic [hwp_pkg::IDX_W-1:0]    waypoint_index_o
);
  import hwp_pkg::*;

  hwp_cmd_t                         cmd;
  hwp_sts_t                         sts;
  logic [NUM_AXES-1:0][COORD_W-1:0] pos, goal, wp;

  // Gather the axes into vectors; axis 0 is x.
  assign pos  = {pos_z_i, pos_y_i, pos_x_i};
  assign goal = {goal_z_i, goal_y_i, goal_x_i};

  hwp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  hwp_dpath #(
    .NUM_SEGMENTS (NUM_SEGMENTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (kind_i),
    .pos_i       (pos),
    .goal_i      (goal),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wp_o        (wp),
    .reached_o   (reached_o),
    .index_o     (waypoint_index_o),
    .done_o      (done_o)
  );

  // Split the reported waypoint back into its axes.
  assign waypoint_x_o = wp[0];
  assign waypoint_y_o = wp[1];
  assign waypoint_z_o = wp[2];

endmodule

FILE: bench/halving_waypoint_planner_test.sv
// Self-checking bench for halving_waypoint_planner: directed and random words,
// with every result compared against a local model of the waypoint table.
// Depends on hwp_pkg and the halving_waypoint_planner RTL; reads no files.
module halving_waypoint_planner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hwp_pkg::*;

  localparam int unsigned SEGS        = NUM_SEGMENTS_DEF;
  localparam int unsigned HALF        = SEGS / 2;
  localparam int unsigned DEPTH       = SEGS + 1;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [THR_W-1:0]   THR_MAX   = {THR_W{1'b1}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // Axis 0 is x, 1 is y, 2 is z.
  typedef logic [NUM_AXES-1:0][COORD_W-1:0] point_t;

  typedef struct packed {
    point_t           waypoint;
    logic             reached;
    logic [IDX_W-1:0] index;
  } report_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [1:0]                kind_i;
  logic signed [COORD_W-1:0] pos_x_i;
  logic signed [COORD_W-1:0] pos_y_i;
  logic signed [COORD_W-1:0] pos_z_i;
  logic signed [COORD_W-1:0] goal_x_i;
  logic signed [COORD_W-1:0] goal_y_i;
  logic signed [COORD_W-1:0] goal_z_i;
  logic                      cfg_we_i;
  logic [THR_W-1:0]          cfg_wdata_i;
  logic                      done_o;
  logic signed [COORD_W-1:0] waypoint_x_o;
  logic signed [COORD_W-1:0] waypoint_y_o;
  logic signed [COORD_W-1:0] waypoint_z_o;
  logic                      reached_o;
  logic [IDX_W-1:0]          waypoint_index_o;

  // Local copy of the planner state: waypoint table, pointer, threshold.
  logic [COORD_W-1:0] path_table [NUM_AXES][DEPTH];
  logic [IDX_W-1:0]   path_ptr;
  logic [THR_W-1:0]   reach_limit;

  // Reports owed by the block, oldest first.
  report_t     pending_reports[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;

  halving_waypoint_planner dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .goal_x_i         (goal_x_i),
    .goal_y_i         (goal_y_i),
    .goal_z_i         (goal_z_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .waypoint_x_o     (waypoint_x_o),
    .waypoint_y_o     (waypoint_y_o),
    .waypoint_z_o     (waypoint_z_o),
    .reached_o        (reached_o),
    .waypoint_index_o (waypoint_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: end the run as failed if it has not finished in time.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Waypoint the pointer currently selects, as the model holds it.
  function automatic point_t current_waypoint();
    point_t wp;
    for (int a = 0; a < NUM_AXES; a++) wp[a] = path_table[a][path_ptr];
    return wp;
  endfunction

  // Apply one accepted word to the model and queue the report it owes.
  task automatic predict_report(hwp_kind_e kind, point_t pos, point_t goal);
    report_t rep;
    longint  span;
    longint  part;
    longint  gap;
    rep.reached = 1'b0;
    case (kind)
      KIND_PLAN: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          // Take the distance at full width so extremes cannot overflow.
          span = longint'($signed(goal[a])) - longint'($signed(pos[a]));
          path_table[a][0] = pos[a];
          // Fill from the middle outward; the high half overwrites the midpoint.
          for (int i = 0; i < HALF; i++) begin
            part = span >>> (i + 1);
            path_table[a][HALF - i] = COORD_W'(longint'($signed(pos[a])) + part);
            path_table[a][HALF + i] = COORD_W'(longint'($signed(goal[a])) - part);
          end
          path_table[a][SEGS] = goal[a];
        end
        path_ptr = '0;
      end
      KIND_CHECK: begin
        rep.reached = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
          gap = longint'($signed(path_table[a][path_ptr])) - longint'($signed(pos[a]));
          if (gap < 0) gap = -gap;
          if (!(longint'(reach_limit) > gap)) rep.reached = 1'b0;
        end
      end
      KIND_ADVANCE: begin
        // Hold the pointer once it sits on the target.
        if (path_ptr < SEGS) path_ptr++;
      end
      default: begin
      end
    endcase
    rep.waypoint = current_waypoint();
    rep.index    = path_ptr;
    pending_reports.push_back(rep);
  endtask

  // Present one word and hold it until the block takes it.
  task automatic send_word(hwp_kind_e kind, point_t pos, point_t goal);
    kind_i   <= kind;
    pos_x_i  <= pos[0];
    pos_y_i  <= pos[1];
    pos_z_i  <= pos[2];
    goal_x_i <= goal[0];
    goal_y_i <= goal[1];
    goal_z_i <= goal[2];
    start    <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_report(kind, pos, goal);
  endtask

  // Drop start for a short random burst.
  task automatic pause_sender();
    start <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  // Stop sending and wait until every owed report has come back.
  task automatic drain_reports();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the threshold only once the block has gone idle.
  task automatic write_threshold(logic [THR_W-1:0] value);
    drain_reports();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reach_limit = value;
    @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each strobed result with the oldest owed report.
  always @(posedge clk_i) begin : result_monitor
    report_t want;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $error("result strobed with no word outstanding");
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("waypoint_x", want.waypoint[0], waypoint_x_o);
        check_field("waypoint_y", want.waypoint[1], waypoint_y_o);
        check_field("waypoint_z", want.waypoint[2], waypoint_z_o);
        check_field("reached", COORD_W'(want.reached), COORD_W'(reached_o));
        check_field("waypoint_index", COORD_W'(want.index), COORD_W'(waypoint_index_o));
      end
    end
  end

  // Mix extremes, full-range noise and small coordinates that keep paths short.
  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return COORD_MIN;
    if (r == 1) return COORD_MAX;
    if (r < 4) return $urandom();
    return COORD_W'(longint'($urandom_range(0, 1 << 21)) - (longint'(1) << 20));
  endfunction

  function automatic point_t rand_point();
    point_t p;
    for (int a = 0; a < NUM_AXES; a++) p[a] = rand_coord();
    return p;
  endfunction

  // Aim near the waypoint: on it, inside the threshold, at its edge, or anywhere.
  function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] wp);
    int unsigned r;
    longint      mag;
    r = $urandom_range(0, 19);
    if (r < 5) mag = 0;
    else if (r < 14) mag = longint'($urandom_range(0, reach_limit));
    else if (r < 17) mag = (reach_limit == 0) ? 0 :
                           longint'(reach_limit) - longint'($urandom_range(0, 1));
    else return $urandom();
    if ($urandom_range(0, 1) == 1) mag = -mag;
    return COORD_W'(longint'($signed(wp)) + mag);
  endfunction

  function automatic point_t near_point();
    point_t wp;
    point_t p;
    wp = current_waypoint();
    for (int a = 0; a < NUM_AXES; a++) p[a] = near_coord(wp[a]);
    return p;
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return THR_MAX;
    if (r == 2) return THR_RESET;
    if (r == 3) return THR_W'($urandom());
    if (r == 4) return THR_W'($urandom_range(0, 1000));
    return THR_W'($urandom_range(0, 1 << 22));
  endfunction

  // Plan between opposite extremes and check the start waypoint.
  task automatic test_walk_path();
    point_t from_pt;
    point_t to_pt;
    from_pt = {COORD_W'(0), COORD_MAX, COORD_MIN};
    to_pt   = {COORD_W'(0), COORD_MIN, COORD_MAX};
    send_word(KIND_PLAN, from_pt, to_pt);
    send_word(KIND_CHECK, current_waypoint(), to_pt);
  endtask

  // Threshold at its extremes and at the strict edge of the comparison.
  task automatic test_threshold_edges();
    point_t probe;
    write_threshold(THR_MAX);
    // Waypoint x sits at the minimum: the widest possible distance.
    probe    = current_waypoint();
    probe[0] = COORD_MAX;
    send_word(KIND_CHECK, probe, probe);
    send_word(KIND_CHECK, current_waypoint(), probe);
    // A zero threshold never counts as reached, not even on the waypoint.
    write_threshold('0);
    send_word(KIND_CHECK, current_waypoint(), probe);
    write_threshold(THR_W'(5));
    probe    = current_waypoint();
    probe[2] = probe[2] + COORD_W'(5);
    send_word(KIND_CHECK, probe, probe);
    probe[2] = probe[2] - COORD_W'(9);
    send_word(KIND_CHECK, probe, probe);
    write_threshold(THR_RESET);
  endtask

  // Walk the whole path, then advance once more at the target.
  task automatic test_pointer_saturation();
    for (int s = 0; s <= SEGS; s++) begin
      if (s % 5 == 4) pause_sender();
      send_word(KIND_ADVANCE, rand_point(), rand_point());
    end
    send_word(KIND_CHECK, current_waypoint(), rand_point());
    send_word(KIND_UNUSED, rand_point(), rand_point());
  endtask

  // Distances of -1 and 16 exercise rounding of the halving shifts.
  task automatic test_plan_rounding();
    point_t from_pt;
    point_t to_pt;
    from_pt = {COORD_W'(-7), COORD_W'(100), COORD_W'(0)};
    to_pt   = {COORD_W'(9), COORD_W'(99), COORD_W'(-1)};
    send_word(KIND_PLAN, from_pt, to_pt);
    send_word(KIND_ADVANCE, from_pt, to_pt);
    pause_sender();
    send_word(KIND_ADVANCE, from_pt, to_pt);
    send_word(KIND_CHECK, current_waypoint(), to_pt);
  endtask

  // Random flights: a plan followed by a run of checks and advances, with noise.
  task automatic test_random_flight(int unsigned word_count, bit with_gaps);
    int unsigned sent;
    int unsigned legs;
    int unsigned r;
    sent = 0;
    while (sent < word_count) begin
      if (with_gaps && $urandom_range(0, 2) == 0) pause_sender();
      send_word(KIND_PLAN, rand_point(), rand_point());
      sent++;
      legs = $urandom_range(4, 48);
      for (int s = 0; s < legs && sent < word_count; s++) begin
        if (with_gaps && $urandom_range(0, 3) == 0) pause_sender();
        r = $urandom_range(0, 99);
        if (r < 38) send_word(KIND_ADVANCE, rand_point(), rand_point());
        else if (r < 85) send_word(KIND_CHECK, near_point(), rand_point());
        else if (r < 92) send_word(KIND_CHECK, rand_point(), rand_point());
        else if (r < 97) send_word(KIND_UNUSED, rand_point(), rand_point());
        else send_word(KIND_PLAN, rand_point(), rand_point());
        sent++;
      end
      // Retune the threshold between flights, once the block is idle.
      if (with_gaps && $urandom_range(0, 5) == 0) write_threshold(pick_threshold());
    end
  endtask

  initial begin
    mismatch_count = 0;
    path_ptr       = '0;
    reach_limit    = THR_RESET;
    for (int a = 0; a < NUM_AXES; a++)
      for (int e = 0; e < DEPTH; e++) path_table[a][e] = '0;

    rst_ni      <= 1'b0;
    start       <= 1'b0;
    kind_i      <= KIND_PLAN;
    pos_x_i     <= '0;
    pos_y_i     <= '0;
    pos_z_i     <= '0;
    goal_x_i    <= '0;
    goal_y_i    <= '0;
    goal_z_i    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The table is unwritten after reset, so open with a plan.
    test_walk_path();
    test_threshold_edges();
    test_pointer_saturation();
    test_plan_rounding();
    test_random_flight(1450, 1'b1);
    // Run the tail back to back with no idle cycles.
    test_random_flight(200, 1'b0);

    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
